// File: hdl/bsta_pkg.sv
// bsta_pkg: shared types and codes for the burst assembler
// holds the flush cause enum, register indexes, config and result structs
// no dependencies
package bsta_pkg;

	typedef enum logic [1:0] {
		CAUSE_NONE      = 2'd0,
		CAUSE_THRESHOLD = 2'd1,
		CAUSE_TIMEOUT   = 2'd2
	} cause_t;

	// register indexes on the configuration port
	localparam logic [2:0] REG_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_TIMEOUT   = 3'd1;
	localparam logic [2:0] REG_PKT_BYTES = 3'd2;
	localparam logic [2:0] REG_SOURCE_ID = 3'd3;
	localparam logic [2:0] REG_DEST_ID   = 3'd4;

	localparam logic KIND_ARRIVAL = 1'b0;
	localparam logic KIND_TICK    = 1'b1;

	localparam logic [1:0] CLASS_VOICE = 2'd0;
	localparam logic [1:0] CLASS_DATA  = 2'd1;

	localparam logic [7:0]  THRESHOLD_RST = 8'd24;
	localparam logic [15:0] TIMEOUT_RST   = 16'd10000;
	localparam logic [15:0] PKT_BYTES_RST = 16'd200;

	typedef struct packed {
		logic [7:0]  threshold;
		logic [15:0] timeout_ticks;
		logic [15:0] packet_bytes;
		logic [7:0]  source_id;
		logic [7:0]  dest_id;
	} cfg_t;

	// first member is the top bits: flushed ends up in bit 0 when packed
	typedef struct packed {
		logic [7:0]  total_buffered;
		logic [23:0] burst_bytes;
		logic [7:0]  burst_video;
		logic [7:0]  burst_data;
		logic [7:0]  burst_voice;
		logic [7:0]  burst_dest;
		logic [7:0]  burst_source;
		logic [15:0] burst_id;
		cause_t      flush_cause;
		logic        flushed;
	} res_t;

	localparam int RES_W  = $bits(res_t);
	localparam int TDATA_OUT_W = ((RES_W + 7) / 8) * 8;

endpackage

// File: hdl/bsta_core.sv
// bsta_core: assembly state and the per-beat update of the burst assembler
// holds class counters, tick timer and burst id; builds one result per step
// depends on bsta_pkg
module bsta_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step_en,
	input  logic          kind,
	input  logic [1:0]    service_class,
	input  bsta_pkg::cfg_t cfg,
	output bsta_pkg::res_t res
);
	import bsta_pkg::*;

	logic [7:0]  voice_q, data_q, video_q;
	logic        assembling_q;
	logic [15:0] elapsed_q;
	logic [15:0] next_id_q;

	logic [7:0]  voice_n, data_n, video_n;
	logic        assembling_n;
	logic [15:0] elapsed_n;
	logic [9:0]  tot;
	logic        close;
	logic        emit;
	cause_t      cause;
	logic [25:0] bytes_full;

	function automatic logic [7:0] bump8(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	always_comb begin
		voice_n      = voice_q;
		data_n       = data_q;
		video_n      = video_q;
		assembling_n = assembling_q;
		elapsed_n    = elapsed_q;
		close        = 1'b0;
		cause        = CAUSE_NONE;
		if (kind == KIND_ARRIVAL) begin
			case (service_class)
				CLASS_VOICE: voice_n = bump8(voice_q);
				CLASS_DATA:  data_n  = bump8(data_q);
				default:     video_n = bump8(video_q);
			endcase
			if (!assembling_q) begin
				assembling_n = 1'b1;
				elapsed_n    = 16'd0;
			end
		end else if (assembling_q) begin
			if (elapsed_q != 16'hFFFF)
				elapsed_n = elapsed_q + 16'd1;
		end
		tot = {2'b00, voice_n} + {2'b00, data_n} + {2'b00, video_n};
		if (kind == KIND_ARRIVAL) begin
			if (tot >= {2'b00, cfg.threshold}) begin
				close = 1'b1;
				cause = CAUSE_THRESHOLD;
			end
		end else if (assembling_q && elapsed_n >= cfg.timeout_ticks) begin
			close = 1'b1;
			cause = CAUSE_TIMEOUT;
		end
		if (close)
			assembling_n = 1'b0;
		// a close with nothing held only drops back to idle
		emit = close && (tot != 10'd0);
	end

	assign bytes_full = tot * cfg.packet_bytes;

	always_comb begin
		res = '0;
		if (emit) begin
			res.flushed      = 1'b1;
			res.flush_cause  = cause;
			res.burst_id     = next_id_q;
			res.burst_source = cfg.source_id;
			res.burst_dest   = cfg.dest_id;
			res.burst_voice  = voice_n;
			res.burst_data   = data_n;
			res.burst_video  = video_n;
			res.burst_bytes  = bytes_full[23:0];
			res.total_buffered = 8'd0;
		end else begin
			res.total_buffered = tot[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_q      <= '0;
			data_q       <= '0;
			video_q      <= '0;
			assembling_q <= 1'b0;
			elapsed_q    <= '0;
			next_id_q    <= '0;
		end else if (step_en) begin
			assembling_q <= assembling_n;
			elapsed_q    <= elapsed_n;
			if (emit) begin
				voice_q   <= '0;
				data_q    <= '0;
				video_q   <= '0;
				next_id_q <= next_id_q + 16'd1;
			end else begin
				voice_q <= voice_n;
				data_q  <= data_n;
				video_q <= video_n;
			end
		end
	end

endmodule

// File: hdl/burst_assembler_threshold_timeout.sv
// burst_assembler_threshold_timeout: top level of the burst assembler
// holds the configuration registers, input stage and result register
// depends on bsta_pkg and bsta_core
//
// channel   dir  width  contents
// s_axis    in   8+1    tdata: service_class; tuser: kind
// m_axis    out  96     tdata: result fields, flushed in bit 0
// cfg       in   3+16   write enable, register index, write data
//
// one beat per cycle sustained while m_axis_tready holds; a beat is registered in the input stage
// and is updated against the assembly state on its way into the result register
// the state update is a saturating count, a small sum, a threshold or timeout compare and a
// 10 x 16 multiply for the byte count, all in that single step
// a stalled m_axis fills the input stage, then s_axis_tready drops
// reset clears the assembly state and the pipeline valids and loads the configuration defaults
module burst_assembler_threshold_timeout (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [1:0] service_class, rest zero
	input  logic        s_axis_tuser,   // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [bsta_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
	// m_axis_tdata from bit 0: flushed, flush_cause, burst_id, burst_source,
	// burst_dest, burst_voice, burst_data, burst_video, burst_bytes,
	// total_buffered, zero fill
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import bsta_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic       kind_s1;
	logic [1:0] class_s1;
	logic       out_valid_q;
	res_t       res_q;
	res_t       res_next;
	logic       adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold     <= THRESHOLD_RST;
			cfg_q.timeout_ticks <= TIMEOUT_RST;
			cfg_q.packet_bytes  <= PKT_BYTES_RST;
			cfg_q.source_id     <= 8'd0;
			cfg_q.dest_id       <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_THRESHOLD: cfg_q.threshold     <= cfg_wdata[7:0];
				REG_TIMEOUT:   cfg_q.timeout_ticks <= cfg_wdata;
				REG_PKT_BYTES: cfg_q.packet_bytes  <= cfg_wdata;
				REG_SOURCE_ID: cfg_q.source_id     <= cfg_wdata[7:0];
				REG_DEST_ID:   cfg_q.dest_id       <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// beat moves from the input stage into the result register
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1  <= s_axis_tuser;
			class_s1 <= s_axis_tdata[1:0];
		end
	end

	bsta_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (adv),
		.kind          (kind_s1),
		.service_class (class_s1),
		.cfg           (cfg_q),
		.res           (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_next;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(TDATA_OUT_W - RES_W){1'b0}}, res_q};

endmodule

// File: tb/tb_burst_assembler_threshold_timeout.sv
`timescale 1ns / 100ps
// tb_burst_assembler_threshold_timeout: self-checking bench for the burst assembler
// drives packet and tick beats, predicts each result beat and compares it field by field
// depends on bsta_pkg and burst_assembler_threshold_timeout
module tb_burst_assembler_threshold_timeout;
	import bsta_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int HOLD_AT     = 250;
	localparam int CALM_FIRST  = 500;
	localparam int CALM_LAST   = 700;
	localparam int TAIL_CYCLES = 20;

	localparam logic [1:0] CLASS_VIDEO = 2'd2;
	localparam logic [1:0] CLASS_SPARE = 2'd3;

	typedef struct packed {
		logic       kind;
		logic [1:0] svc;
	} traffic_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;    // [1:0] service_class, rest zero
	logic s_axis_tuser = 1'b0;        // [0] kind
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;   // flushed, flush_cause, burst_id, burst_source,
	                                        // burst_dest, voice, data, video, bytes, total
	logic cfg_we = 1'b0;
	logic [2:0] cfg_addr = REG_THRESHOLD;
	logic [15:0] cfg_wdata = '0;

	// shadow registers and assembly state of the predictor
	logic [7:0]  thr_q, src_q, dst_q;
	logic [15:0] tmo_q, bytes_q;
	logic [7:0]  voice_q, data_q, video_q;
	logic        assembling_q;
	logic [15:0] ticks_q, id_q;

	traffic_t traffic_q[$];
	res_t     results_due[$];
	int n_sent = 0;
	int n_got = 0;
	int errors = 0;
	int idle_cycles = 0;
	int hold_left = 0;
	logic held_off = 1'b0;

	burst_assembler_threshold_timeout DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic res_t assemble_step(traffic_t t);
		res_t r;
		logic [9:0] held;
		logic [31:0] prod;
		logic close;
		cause_t cause;
		r = '0;
		close = 1'b0;
		cause = CAUSE_NONE;
		if (t.kind == KIND_ARRIVAL) begin
			case (t.svc)
				CLASS_VOICE: if (voice_q != 8'hff) voice_q = voice_q + 8'd1;
				CLASS_DATA:  if (data_q != 8'hff) data_q = data_q + 8'd1;
				default:     if (video_q != 8'hff) video_q = video_q + 8'd1;
			endcase
			if (!assembling_q) begin
				assembling_q = 1'b1;
				ticks_q = '0;
			end
			held = {2'b0, voice_q} + {2'b0, data_q} + {2'b0, video_q};
			if (held >= {2'b0, thr_q}) begin
				close = 1'b1;
				cause = CAUSE_THRESHOLD;
			end
		end else if (assembling_q) begin
			// tick counter sticks at its top value
			if (ticks_q != 16'hffff)
				ticks_q = ticks_q + 16'd1;
			if (ticks_q >= tmo_q) begin
				close = 1'b1;
				cause = CAUSE_TIMEOUT;
			end
		end
		held = {2'b0, voice_q} + {2'b0, data_q} + {2'b0, video_q};
		if (close) begin
			assembling_q = 1'b0;
			if (held != '0) begin
				prod = {22'b0, held} * {16'b0, bytes_q};
				r.flushed = 1'b1;
				r.flush_cause = cause;
				r.burst_id = id_q;
				r.burst_source = src_q;
				r.burst_dest = dst_q;
				r.burst_voice = voice_q;
				r.burst_data = data_q;
				r.burst_video = video_q;
				r.burst_bytes = prod[23:0];
				id_q = id_q + 16'd1;
				voice_q = '0;
				data_q = '0;
				video_q = '0;
				held = '0;
			end
		end
		r.total_buffered = held[7:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_THRESHOLD: thr_q = val[7:0];
			REG_TIMEOUT:   tmo_q = val;
			REG_PKT_BYTES: bytes_q = val;
			REG_SOURCE_ID: src_q = val[7:0];
			REG_DEST_ID:   dst_q = val[7:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [7:0] thr, logic [15:0] tmo, logic [15:0] bytes,
			logic [7:0] src, logic [7:0] dst);
		write_reg(REG_THRESHOLD, {8'b0, thr});
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_PKT_BYTES, bytes);
		write_reg(REG_SOURCE_ID, {8'b0, src});
		write_reg(REG_DEST_ID, {8'b0, dst});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_beat(logic kind, logic [1:0] svc);
		traffic_t t;
		t.kind = kind;
		t.svc = svc;
		traffic_q.push_back(t);
	endtask

	task automatic queue_random(int n, int tick_pct);
		for (int i = 0; i < n; i++)
			queue_beat(($urandom_range(99) < tick_pct) ? KIND_TICK : KIND_ARRIVAL,
				2'($urandom_range(3)));
	endtask

	// sampled at the falling edge so the sender's updates have settled
	task automatic wait_drained;
		while (traffic_q.size() != 0 || s_axis_tvalid || results_due.size() != 0)
			@(negedge clk);
	endtask

	// sender: offers the next queued beat once the current one has gone
	always @(posedge clk or negedge arst_n) begin : drive
		traffic_t t;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				t.kind = s_axis_tuser;
				t.svc = s_axis_tdata[1:0];
				results_due.push_back(assemble_step(t));
				n_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (traffic_q.size() != 0 && ((n_sent >= CALM_FIRST && n_sent < CALM_LAST)
						|| $urandom_range(99) >= 13)) begin
					t = traffic_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= t.kind;
					s_axis_tdata <= {6'b0, t.svc};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result beat, stalls at random and once for a long stretch
	always @(posedge clk or negedge arst_n) begin : observe
		res_t got;
		res_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				n_got++;
				got = m_axis_tdata[RES_W-1:0];
				if (results_due.size() == 0) begin
					$display("%0t: result beat expected none actual %0h", $time, m_axis_tdata);
					errors++;
				end else begin
					want = results_due.pop_front();
					check_field("flushed", want.flushed, got.flushed);
					check_field("flush_cause", want.flush_cause, got.flush_cause);
					check_field("burst_id", want.burst_id, got.burst_id);
					check_field("burst_source", want.burst_source, got.burst_source);
					check_field("burst_dest", want.burst_dest, got.burst_dest);
					check_field("burst_voice", want.burst_voice, got.burst_voice);
					check_field("burst_data", want.burst_data, got.burst_data);
					check_field("burst_video", want.burst_video, got.burst_video);
					check_field("burst_bytes", want.burst_bytes, got.burst_bytes);
					check_field("total_buffered", want.total_buffered, got.total_buffered);
					check_field("zero fill", '0, m_axis_tdata[TDATA_OUT_W-1:RES_W]);
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!held_off && n_got >= HOLD_AT) begin
				// long back-pressure so the input side fills and stalls
				held_off <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= (n_got >= CALM_FIRST && n_got < CALM_LAST)
					|| $urandom_range(99) >= 13;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		thr_q = THRESHOLD_RST;
		tmo_q = TIMEOUT_RST;
		bytes_q = PKT_BYTES_RST;
		src_q = '0;
		dst_q = '0;
		voice_q = '0;
		data_q = '0;
		video_q = '0;
		assembling_q = 1'b0;
		ticks_q = '0;
		id_q = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// ticks while idle, one packet per class (spare class counts as video), ticks below timeout
		queue_beat(KIND_TICK, CLASS_VOICE);
		queue_beat(KIND_TICK, CLASS_SPARE);
		queue_beat(KIND_ARRIVAL, CLASS_VOICE);
		queue_beat(KIND_ARRIVAL, CLASS_DATA);
		queue_beat(KIND_ARRIVAL, CLASS_VIDEO);
		queue_beat(KIND_ARRIVAL, CLASS_SPARE);
		queue_beat(KIND_TICK, CLASS_DATA);
		queue_beat(KIND_TICK, CLASS_VIDEO);
		wait_drained;

		// threshold zero lowered mid-burst: next arrival closes with what is held
		write_all(8'd0, 16'd0, 16'hffff, 8'hff, 8'hff);
		queue_beat(KIND_ARRIVAL, CLASS_DATA);
		queue_beat(KIND_ARRIVAL, CLASS_VIDEO);
		queue_beat(KIND_TICK, CLASS_VOICE);
		wait_drained;

		// timeout zero: first tick after start closes
		write_all(8'd255, 16'd0, 16'hffff, 8'hff, 8'hff);
		queue_beat(KIND_ARRIVAL, CLASS_VOICE);
		queue_beat(KIND_TICK, CLASS_VOICE);
		wait_drained;

		write_all(8'd3, 16'd2, 16'd1, 8'd0, 8'd0);
		queue_beat(KIND_ARRIVAL, CLASS_SPARE);
		queue_beat(KIND_ARRIVAL, CLASS_SPARE);
		queue_beat(KIND_ARRIVAL, CLASS_SPARE);
		queue_beat(KIND_ARRIVAL, CLASS_VOICE);
		queue_beat(KIND_TICK, CLASS_DATA);
		queue_beat(KIND_TICK, CLASS_DATA);
		wait_drained;

		// top of the threshold, timeout, byte and source ranges: longest burst and largest byte count
		write_all(8'd255, 16'hffff, 16'hffff, 8'hff, 8'd0);
		queue_random(300, 5);
		wait_drained;

		for (int p = 0; p < 8; p++) begin
			write_all(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(12)),
				($urandom_range(4) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(24)),
				16'($urandom_range(65535, 1)), 8'($urandom_range(255)), 8'($urandom_range(255)));
			queue_random(100, $urandom_range(70, 20));
			wait_drained;
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && results_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
